### hdl/vector_memo_cache_core_macros.svh
// Assertion macros shared by the checker files of the vector memo cache.
// Each macro takes a label, a trigger expression and a consequence.
`ifndef VECTOR_MEMO_CACHE_CORE_MACROS_SVH
`define VECTOR_MEMO_CACHE_CORE_MACROS_SVH

// Consequence must hold in the same cycle as the trigger.
`define VMC_ASSERT_NOW(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("vmc check failed: same-cycle rule");

// Consequence must hold in the cycle after the trigger.
`define VMC_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("vmc check failed: next-cycle rule");

`endif

### hdl/vmc_pkg.sv
// ----------------------------------------------------------------------------
// vmc_pkg
// Types and codes shared by the vector memo cache modules.
// ----------------------------------------------------------------------------
package vmc_pkg;

	// Command codes carried by an input word.
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_FILL   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_IN_LEN  = 2'd1;
	localparam logic [1:0] REG_OUT_LEN = 2'd2;

	localparam int CFG_W = 5;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] out_value;
		logic        last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_CMP_RD,
		ST_CMP_CK,
		ST_MISS,
		ST_HIT_RD,
		ST_HIT_WR,
		ST_COPY
	} state_t;

endpackage

### hdl/vmc_ram.sv
// ----------------------------------------------------------------------------
// vmc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vmc_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/vmc_out_stage.sv
// ----------------------------------------------------------------------------
// vmc_out_stage
// Output register that holds a result word until the receiver takes it.
// ----------------------------------------------------------------------------
module vmc_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  vmc_pkg::out_word_t load_data,
	output logic               free,
	output logic               out_valid,
	input  logic               out_stall,
	output vmc_pkg::out_word_t out_data
);

	logic               valid_q;
	vmc_pkg::out_word_t data_q;

	// The register can take a new word when empty or when its word leaves.
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### hdl/vector_memo_cache_core.sv
// ----------------------------------------------------------------------------
// vector_memo_cache_core
// Direct-mapped result cache keyed by a vector of signed fixed-point elements.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_stall) carry a command and a value. A lookup word
// adds one element to a rolling hash; the in_len-th element selects a line and
// the stored vector is compared with the arriving one. A hit returns out_len
// words with hit set, a miss one word with hit clear; last marks the final
// word. Fill words then write the output words of the missed line, and the
// last fill copies the pending vector into it. A clear word zeroes both stores.
// Steps per input word: a lookup element that is not the last is taken while
// idle. The last element also forms the line index when LINES is a power of
// two, else the reciprocal modulo unit forms it; then each compared element
// is a store read, then a compare, and each hit word a store read, then an
// output load, set by the single read port of each store; a miss adds an
// output load. A fill is taken while idle; the last fill copies the vector.
// Reset and clear both run a sweep over every store address, which zeroes
// the stores; in_stall is high during the sweep, configuration
// writes are taken as ever. A stalled output word is held in the output
// register; the next input word is taken while it waits, and the block
// pauses only when it needs that register for a new word.
// ----------------------------------------------------------------------------
module vector_memo_cache_core #(
	parameter int LINES   = 1024,
	parameter int IN_MAX  = 16,
	parameter int OUT_MAX = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  vmc_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output vmc_pkg::out_word_t         out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [vmc_pkg::CFG_W-1:0]  cfg_data
);

	localparam int LW        = (LINES > 1) ? $clog2(LINES) : 1;
	localparam bit LINE_POW2 = ((1 << LW) == LINES);
	localparam int MAXL      = (IN_MAX > OUT_MAX) ? IN_MAX : OUT_MAX;
	localparam int KW        = $clog2(MAXL + 1);
	localparam int IW        = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
	localparam int IA        = $clog2(LINES * IN_MAX);
	localparam int OA        = $clog2(LINES * OUT_MAX);
	localparam int CLR_DEPTH = LINES * MAXL;
	localparam int CW        = $clog2(CLR_DEPTH);
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(LINES));

	// Configuration registers.
	logic       enable_q;
	logic [4:0] in_len_q;
	logic [3:0] out_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			in_len_q  <= 5'd16;
			out_len_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				vmc_pkg::REG_ENABLE:  enable_q  <= cfg_data[0];
				vmc_pkg::REG_IN_LEN:  in_len_q  <= cfg_data[4:0];
				vmc_pkg::REG_OUT_LEN: out_len_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Effective lengths: zero acts as one, large values saturate.
	logic [KW-1:0] ilen, olen;

	always_comb begin
		if (in_len_q == 5'd0) begin
			ilen = KW'(1);
		end else if (int'(in_len_q) > IN_MAX) begin
			ilen = KW'(IN_MAX);
		end else begin
			ilen = KW'(in_len_q);
		end
		if (out_len_q == 4'd0) begin
			olen = KW'(1);
		end else if (int'(out_len_q) > OUT_MAX) begin
			olen = KW'(OUT_MAX);
		end else begin
			olen = KW'(out_len_q);
		end
	end

	// Control and datapath registers.
	vmc_pkg::state_t state_q, state_d;
	logic [31:0]     hash_q;
	logic [KW-1:0]   elem_cnt_q;
	logic [LW-1:0]   line_q;
	logic [LW-1:0]   pend_line_q;
	logic            pend_miss_q;
	logic [KW-1:0]   fill_cnt_q;
	logic [KW-1:0]   idx_q;
	logic [CW-1:0]   clr_cnt_q;
	logic [31:0]     div_q;
	logic [31:0]     quo_q;
	logic [LW:0]     rem_q;
	logic [1:0]      mod_cnt_q;
	logic [31:0]     pend_vec_q [IN_MAX];

	// Memory ports.
	logic          in_we, in_re, out_we, out_re;
	logic [IA-1:0] in_waddr, in_raddr;
	logic [OA-1:0] out_waddr, out_raddr;
	logic [31:0]   in_wdata, out_wdata, in_rdata, out_rdata;

	// Output stage controls.
	logic               ost_load, ost_free;
	vmc_pkg::out_word_t ost_data;

	logic          accept;
	logic [31:0]   hash_next;
	logic [KW-1:0] elem_next, fill_next, idx_next;
	logic          last_elem, last_fill, cmp_match;
	logic [63:0]   quo_prod;
	logic [31:0]   quo_back;
	logic [LW:0]   rem_next;
	logic [31:0]   pend_rd;

	assign accept    = in_valid && (state_q == vmc_pkg::ST_IDLE);
	assign hash_next = (hash_q << 5) - hash_q + 32'(in_data.value);
	assign elem_next = elem_cnt_q + KW'(1);
	assign fill_next = fill_cnt_q + KW'(1);
	assign idx_next  = idx_q + KW'(1);
	assign last_elem = (elem_next >= ilen);
	assign last_fill = (fill_next >= olen);
	assign pend_rd   = pend_vec_q[idx_q[IW-1:0]];
	assign cmp_match = (in_rdata == pend_rd);

	// Hash modulo LINES by reciprocal multiplication. The quotient estimate is
	// at most one low, so a single conditional subtract gives the remainder.
	assign quo_prod = 64'(div_q) * 64'(RECIP);
	assign quo_back = div_q - quo_q * 32'(LINES);
	assign rem_next = (rem_q >= (LW+1)'(LINES)) ? rem_q - (LW+1)'(LINES) : rem_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vmc_pkg::ST_CLEAR: begin
				if (clr_cnt_q == CW'(CLR_DEPTH - 1)) state_d = vmc_pkg::ST_IDLE;
			end
			vmc_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_data.cmd)
						vmc_pkg::CMD_LOOKUP: begin
							if (last_elem) begin
								if (!LINE_POW2) state_d = vmc_pkg::ST_MOD;
								else if (enable_q) state_d = vmc_pkg::ST_CMP_RD;
								else state_d = vmc_pkg::ST_MISS;
							end
						end
						vmc_pkg::CMD_FILL: begin
							if (enable_q && pend_miss_q && last_fill) state_d = vmc_pkg::ST_COPY;
						end
						vmc_pkg::CMD_CLEAR: state_d = vmc_pkg::ST_CLEAR;
						default: ;
					endcase
				end
			end
			vmc_pkg::ST_MOD: begin
				if (mod_cnt_q == 2'd2) begin
					state_d = enable_q ? vmc_pkg::ST_CMP_RD : vmc_pkg::ST_MISS;
				end
			end
			vmc_pkg::ST_CMP_RD: state_d = vmc_pkg::ST_CMP_CK;
			vmc_pkg::ST_CMP_CK: begin
				if (!cmp_match) state_d = vmc_pkg::ST_MISS;
				else if (idx_next >= ilen) state_d = vmc_pkg::ST_HIT_RD;
				else state_d = vmc_pkg::ST_CMP_RD;
			end
			vmc_pkg::ST_MISS: begin
				if (ost_free) state_d = vmc_pkg::ST_IDLE;
			end
			vmc_pkg::ST_HIT_RD: state_d = vmc_pkg::ST_HIT_WR;
			vmc_pkg::ST_HIT_WR: begin
				if (ost_free) begin
					state_d = (idx_next >= olen) ? vmc_pkg::ST_IDLE : vmc_pkg::ST_HIT_RD;
				end
			end
			vmc_pkg::ST_COPY: begin
				if (idx_next >= ilen) state_d = vmc_pkg::ST_IDLE;
			end
			default: state_d = vmc_pkg::ST_IDLE;
		endcase
	end

	// Memory and output controls.
	always_comb begin
		in_we     = 1'b0;
		in_waddr  = IA'(pend_line_q) * IA'(IN_MAX) + IA'(idx_q);
		in_wdata  = pend_rd;
		in_re     = 1'b0;
		in_raddr  = IA'(line_q) * IA'(IN_MAX) + IA'(idx_q);
		out_we    = 1'b0;
		out_waddr = OA'(pend_line_q) * OA'(OUT_MAX) + OA'(fill_cnt_q);
		out_wdata = in_data.value;
		out_re    = 1'b0;
		out_raddr = OA'(line_q) * OA'(OUT_MAX) + OA'(idx_q);
		ost_load  = 1'b0;
		ost_data  = '{hit: 1'b0, out_value: 32'd0, last: 1'b1};
		in_stall  = (state_q != vmc_pkg::ST_IDLE);
		unique case (state_q)
			vmc_pkg::ST_CLEAR: begin
				in_we     = 1'b1;
				in_waddr  = clr_cnt_q[IA-1:0];
				in_wdata  = 32'd0;
				out_we    = 1'b1;
				out_waddr = clr_cnt_q[OA-1:0];
				out_wdata = 32'd0;
			end
			vmc_pkg::ST_IDLE: begin
				out_we = accept && (in_data.cmd == vmc_pkg::CMD_FILL) && enable_q && pend_miss_q;
			end
			vmc_pkg::ST_CMP_RD: in_re = 1'b1;
			vmc_pkg::ST_MISS:   ost_load = 1'b1;
			vmc_pkg::ST_HIT_RD: out_re = 1'b1;
			vmc_pkg::ST_HIT_WR: begin
				ost_load = 1'b1;
				ost_data = '{hit: 1'b1, out_value: out_rdata, last: (idx_next >= olen)};
			end
			vmc_pkg::ST_COPY: in_we = 1'b1;
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vmc_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			hash_q      <= '0;
			elem_cnt_q  <= '0;
			pend_line_q <= '0;
			pend_miss_q <= 1'b0;
			fill_cnt_q  <= '0;
			idx_q       <= '0;
			mod_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				vmc_pkg::ST_CLEAR: clr_cnt_q <= clr_cnt_q + CW'(1);
				vmc_pkg::ST_IDLE: begin
					if (accept) begin
						case (in_data.cmd)
							vmc_pkg::CMD_LOOKUP: begin
								if (elem_cnt_q == '0) pend_miss_q <= 1'b0;
								idx_q     <= '0;
								mod_cnt_q <= '0;
								if (last_elem) begin
									hash_q     <= '0;
									elem_cnt_q <= '0;
								end else begin
									hash_q     <= hash_next;
									elem_cnt_q <= elem_next;
								end
							end
							vmc_pkg::CMD_FILL: begin
								if (enable_q && pend_miss_q) begin
									idx_q <= '0;
									if (last_fill) begin
										fill_cnt_q  <= '0;
										pend_miss_q <= 1'b0;
									end else begin
										fill_cnt_q <= fill_next;
									end
								end
							end
							vmc_pkg::CMD_CLEAR: begin
								clr_cnt_q   <= '0;
								hash_q      <= '0;
								elem_cnt_q  <= '0;
								pend_miss_q <= 1'b0;
								fill_cnt_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				vmc_pkg::ST_MOD: mod_cnt_q <= mod_cnt_q + 2'd1;
				vmc_pkg::ST_CMP_CK: begin
					idx_q <= (cmp_match && idx_next < ilen) ? idx_next : '0;
				end
				vmc_pkg::ST_MISS: begin
					if (ost_free) begin
						pend_line_q <= line_q;
						pend_miss_q <= enable_q;
						fill_cnt_q  <= '0;
					end
				end
				vmc_pkg::ST_HIT_WR: begin
					if (ost_free) idx_q <= idx_next;
				end
				vmc_pkg::ST_COPY: idx_q <= idx_next;
				default: ;
			endcase
		end
	end

	// Payload registers: pending vector, line index and modulo unit.
	always_ff @(posedge clk) begin
		if (accept && in_data.cmd == vmc_pkg::CMD_LOOKUP) begin
			pend_vec_q[elem_cnt_q[IW-1:0]] <= in_data.value;
			if (last_elem) begin
				line_q <= hash_next[LW-1:0];
				div_q  <= hash_next;
			end
		end
		if (state_q == vmc_pkg::ST_MOD) begin
			case (mod_cnt_q)
				2'd0:    quo_q  <= quo_prod[63:32];
				2'd1:    rem_q  <= quo_back[LW:0];
				default: line_q <= rem_next[LW-1:0];
			endcase
		end
	end

	vmc_ram #(.W(32), .DEPTH(LINES * IN_MAX)) u_input_store (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (in_wdata),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	vmc_ram #(.W(32), .DEPTH(LINES * OUT_MAX)) u_output_store (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (out_wdata),
		.re    (out_re),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	vmc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ost_load),
		.load_data (ost_data),
		.free      (ost_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### hdl/vmc_checker.sv
// ----------------------------------------------------------------------------
// vmc_checker
// Port-level checks of the vector memo cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector_memo_cache_core_macros.svh"

module vmc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input vmc_pkg::out_word_t out_data
);

	// A stalled result word stays in place.
	`VMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// A miss is a single zero word that closes its lookup.
	`VMC_ASSERT_NOW(a_miss_form, out_valid && !out_data.hit, out_data.last && out_data.out_value == '0)

	// While a hit word that is not the last is shown, no new input word is taken.
	`VMC_ASSERT_NOW(a_hit_busy, out_valid && out_data.hit && !out_data.last, in_stall)

endmodule

bind vector_memo_cache_core vmc_checker u_vmc_checker (.*);

### verif/tb_vector_memo_cache_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_memo_cache_core
// Self-checking bench for the vector memo cache core.
// ----------------------------------------------------------------------------
// A cache predictor in the bench tracks both stores, the rolling hash and the
// pending miss, and queues the result words that every accepted input word
// should cause. A monitor compares each accepted output word with the oldest
// queued word. Directed tests cover the length extremes, hits, misses, fills,
// clears and the odd commands; random phases replay a small pool of vectors so
// that hits are common, with some noise mixed in.
// ----------------------------------------------------------------------------
module tb_vector_memo_cache_core;

	localparam int LINES   = 1024;
	localparam int IN_MAX  = 16;
	localparam int OUT_MAX = 8;
	localparam int SWEEP   = LINES * IN_MAX;
	localparam int DOG_LIMIT = 3 * SWEEP + 2000;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	vmc_pkg::in_word_t in_data;
	logic out_valid;
	logic out_stall;
	vmc_pkg::out_word_t out_data;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [vmc_pkg::CFG_W-1:0] cfg_data;

	vector_memo_cache_core #(.LINES(LINES), .IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [31:0] key_store [LINES*IN_MAX];
	logic [31:0] word_store [LINES*OUT_MAX];
	logic [31:0] miss_vec [IN_MAX];
	logic [31:0] hash_sum;
	int unsigned elem_cnt;
	int unsigned miss_line;
	bit miss_open;
	int unsigned fill_cnt;
	bit cache_on;
	logic [4:0] in_len_reg;
	logic [3:0] out_len_reg;

	vmc_pkg::out_word_t expected_q[$];
	int errors;
	int words_sent;
	int words_seen;
	int hits_seen;
	int dog;
	bit quiet;
	bit hold_off;
	logic [31:0] pool [8][IN_MAX];

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_len(int unsigned r, int unsigned mx);
		if (r == 0) return 1;
		if (r > mx) return mx;
		return r;
	endfunction

	task automatic wipe_stores();
		foreach (key_store[i]) key_store[i] = '0;
		foreach (word_store[i]) word_store[i] = '0;
	endtask

	// Advance the cache predictor by one word and queue its results.
	task automatic predict_cache(vmc_pkg::in_word_t w);
		int unsigned ilen;
		int unsigned olen;
		int unsigned line;
		bit match;
		vmc_pkg::out_word_t r;
		ilen = eff_len(in_len_reg, IN_MAX);
		olen = eff_len(out_len_reg, OUT_MAX);
		case (w.cmd)
			vmc_pkg::CMD_LOOKUP: begin
				if (elem_cnt == 0) miss_open = 1'b0;
				if (elem_cnt < IN_MAX) miss_vec[elem_cnt] = w.value;
				hash_sum = hash_sum * 32'd31 + w.value;
				elem_cnt++;
				if (elem_cnt >= ilen) begin
					line = hash_sum % LINES;
					hash_sum = '0;
					elem_cnt = 0;
					match = cache_on;
					for (int i = 0; i < ilen; i++)
						if (key_store[line*IN_MAX+i] != miss_vec[i]) match = 1'b0;
					if (match) begin
						for (int i = 0; i < olen; i++) begin
							r.hit = 1'b1;
							r.out_value = word_store[line*OUT_MAX+i];
							r.last = (i + 1 == olen);
							expected_q.push_back(r);
						end
					end else begin
						miss_line = line;
						miss_open = cache_on;
						fill_cnt = 0;
						r.hit = 1'b0;
						r.out_value = '0;
						r.last = 1'b1;
						expected_q.push_back(r);
					end
				end
			end
			vmc_pkg::CMD_FILL: begin
				if (cache_on && miss_open) begin
					if (fill_cnt < OUT_MAX) word_store[miss_line*OUT_MAX+fill_cnt] = w.value;
					fill_cnt++;
					if (fill_cnt >= olen) begin
						for (int i = 0; i < ilen; i++)
							key_store[miss_line*IN_MAX+i] = miss_vec[i];
						miss_open = 1'b0;
						fill_cnt = 0;
					end
				end
			end
			vmc_pkg::CMD_CLEAR: begin
				wipe_stores();
				hash_sum = '0;
				elem_cnt = 0;
				miss_open = 1'b0;
				fill_cnt = 0;
			end
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH word %0d %s: got %h, expected %h", words_seen, what, got, want);
	endtask

	// Output monitor and checker.
	always @(posedge clk) begin
		vmc_pkg::out_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report("unexpected word", out_data.out_value, '0);
			end else begin
				e = expected_q.pop_front();
				if (out_data.hit !== e.hit) report("hit", 32'(out_data.hit), 32'(e.hit));
				if (out_data.out_value !== e.out_value)
					report("out_value", out_data.out_value, e.out_value);
				if (out_data.last !== e.last) report("last", 32'(out_data.last), 32'(e.last));
				if (e.hit) hits_seen++;
			end
			words_seen++;
		end
	end

	// Receiver stall: random bursts, a long hold-off on request, none when quiet.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(9) == 0) begin
				n = $urandom_range(11, 1);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) dog <= 0;
		else dog <= dog + 1;
		if (dog > DOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Send one word, with an optional random gap before it.
	task automatic send_word(logic [1:0] c, logic [31:0] v);
		vmc_pkg::in_word_t w;
		if (!quiet && $urandom_range(7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(11, 1)) @(negedge clk);
		end
		w.cmd = c;
		w.value = v;
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_cache(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	// One register write; the enable drops again before the next write may start.
	task automatic write_reg(logic [1:0] idx, logic [vmc_pkg::CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vmc_pkg::REG_ENABLE: cache_on = v[0];
			vmc_pkg::REG_IN_LEN: in_len_reg = v[4:0];
			vmc_pkg::REG_OUT_LEN: out_len_reg = v[3:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_lengths(int il, int ol);
		go_idle();
		write_reg(vmc_pkg::REG_IN_LEN, vmc_pkg::CFG_W'(il));
		write_reg(vmc_pkg::REG_OUT_LEN, vmc_pkg::CFG_W'(ol));
	endtask

	task automatic send_vector(int p, int n);
		for (int i = 0; i < n; i++) send_word(vmc_pkg::CMD_LOOKUP, pool[p][i]);
	endtask

	task automatic send_fills(int n);
		for (int i = 0; i < n; i++) send_word(vmc_pkg::CMD_FILL, $urandom());
	endtask

	// Directed: extremes of values, miss then fill then hit, odd commands.
	task automatic test_directed();
		go_idle();
		write_reg(vmc_pkg::REG_ENABLE, vmc_pkg::CFG_W'(1));
		set_lengths(1, 1);
		send_word(vmc_pkg::CMD_LOOKUP, 32'h8000_0000);
		send_word(vmc_pkg::CMD_FILL, 32'hFFFF_FFFF);
		send_word(vmc_pkg::CMD_LOOKUP, 32'h8000_0000);
		send_word(vmc_pkg::CMD_LOOKUP, 32'h7FFF_FFFF);
		send_word(vmc_pkg::CMD_FILL, 32'h0000_0000);
		send_word(vmc_pkg::CMD_LOOKUP, 32'h7FFF_FFFF);
		send_word(CMD_SPARE, 32'h1234_5678);
		send_word(vmc_pkg::CMD_FILL, 32'h5555_5555);
		set_lengths(16, 8);
		send_vector(0, 16);
		send_fills(8);
		send_vector(0, 16);
		send_word(vmc_pkg::CMD_CLEAR, 32'h0);
		send_vector(0, 16);
	endtask

	// Special cases: cancel by new lookup, enable off, clear mid-vector, odd lengths.
	task automatic test_corners();
		set_lengths(3, 2);
		send_vector(1, 3);
		send_word(vmc_pkg::CMD_FILL, 32'hAAAA_AAAA);
		send_vector(2, 3);
		send_fills(2);
		send_vector(2, 3);
		send_vector(1, 2);
		send_word(vmc_pkg::CMD_CLEAR, 32'h0);
		send_vector(2, 3);
		go_idle();
		write_reg(vmc_pkg::REG_ENABLE, vmc_pkg::CFG_W'(0));
		send_vector(3, 3);
		send_fills(2);
		go_idle();
		write_reg(vmc_pkg::REG_ENABLE, vmc_pkg::CFG_W'(1));
		set_lengths(0, 0);
		send_vector(4, 1);
		send_fills(1);
		send_vector(4, 1);
		set_lengths(31, 15);
		send_vector(5, 16);
		send_fills(8);
		send_vector(5, 16);
	endtask

	// Random traffic drawn from a small vector pool so that hits recur.
	task automatic test_random(int budget);
		int il;
		int p;
		int k;
		while (budget > 0) begin
			il = ($urandom_range(5) == 0) ? $urandom_range(16, 1) : $urandom_range(4, 1);
			set_lengths(il, $urandom_range(8, 1));
			repeat (6) begin
				p = $urandom_range(7);
				k = $urandom_range(9);
				if (k == 0) send_word(2'($urandom_range(3)), $urandom());
				else if (k == 1) send_vector(p, $urandom_range(il, 1));
				else begin
					send_vector(p, il);
					if (k > 4) send_fills($urandom_range(8, 1));
				end
				budget -= il + 4;
			end
		end
	endtask

	// Pressure: receiver holds off while hits keep coming, then a drain pause.
	task automatic test_pressure();
		set_lengths(1, 8);
		send_vector(6, 1);
		send_fills(8);
		hold_off = 1'b1;
		repeat (20) send_vector(6, 1);
		go_idle();
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		words_seen = 0;
		hits_seen = 0;
		dog = 0;
		quiet = 1'b0;
		hold_off = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = vmc_pkg::REG_ENABLE;
		cfg_data = '0;
		cache_on = 1'b0;
		in_len_reg = 5'd16;
		out_len_reg = 4'd8;
		hash_sum = '0;
		elem_cnt = 0;
		miss_line = 0;
		miss_open = 1'b0;
		fill_cnt = 0;
		foreach (miss_vec[i]) miss_vec[i] = '0;
		wipe_stores();
		foreach (pool[i, j]) pool[i][j] = $urandom();
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_corners();
		test_pressure();
		test_random(340);
		quiet = 1'b1;
		test_random(60);
		go_idle();
		$display("Sent %0d input words; checked %0d result words, %0d of them hits.",
			words_sent, words_seen, hits_seen);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
